### rtl/utf8_to_utf16_converter_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8 to utf16 converter: assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_CONVERTER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define U8U16_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("u8u16 check failed");

// next-cycle implication
`define U8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("u8u16 check failed");

`endif

### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types, constants and helpers of the utf8 to utf16 converter
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    // unit counter saturates at the smaller of COUNT_MAX and 0xffff
    localparam logic [31:0] COUNT_MAX   = 32'd65535;
    localparam logic [15:0] COUNT_LIMIT =
        (COUNT_MAX > 32'h0000_FFFF) ? 16'hFFFF : COUNT_MAX[15:0];

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // one queue entry: a classified byte that produces one or two results
    typedef struct packed {
        t_kind       kind;
        logic [15:0] unit;
        logic [15:0] count;
        logic        pair;
        logic [9:0]  lo;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c < COUNT_LIMIT) ? c + 16'd1 : c;
    endfunction

endpackage

`default_nettype wire

### rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// accepts utf-8 bytes, tracks the open sequence and the unit count, and
// pushes one command per byte that gives a result
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front import u8u16_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire t_q_stat    i_q_stat,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;
    logic [15:0] r_cnt, n_cnt;

    logic        accept;
    logic [20:0] acc_shift;
    logic [20:0] cp_off;
    logic [15:0] cnt_one;
    logic [15:0] cnt_two;
    logic        overlong;

    assign accept    = i_in_valid && !i_q_stat.full;
    assign acc_shift = {r_acc[14:0], i_in_byte[5:0]};
    assign cp_off    = acc_shift - 21'h010000;
    assign cnt_one   = sat_inc(r_cnt);
    assign cnt_two   = sat_inc(cnt_one);
    assign overlong  = ((r_len == 3'd2) && (acc_shift < 21'h000080)) ||
                       ((r_len == 3'd3) && (acc_shift < 21'h000800)) ||
                       ((r_len == 3'd4) && (acc_shift < 21'h010000));

    always_comb begin
        n_pend = r_pend;
        n_len  = r_len;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_cmd  = '{kind: KIND_ERR, unit: 16'd0, count: 16'd0, pair: 1'b0, lo: 10'd0};
        if (accept) begin
            if (r_pend != 2'd0) begin
                if (i_in_byte[7:6] != 2'b10) begin
                    o_push = 1'b1;
                end else if (r_pend != 2'd1) begin
                    n_pend = r_pend - 2'd1;
                    n_acc  = acc_shift;
                end else if (overlong) begin
                    o_push = 1'b1;
                end else if ((acc_shift < 21'h00D800) ||
                             ((acc_shift >= 21'h00E000) && (acc_shift < 21'h010000))) begin
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_UNIT;
                    o_cmd.unit = acc_shift[15:0];
                end else if ((acc_shift < 21'h00E000) || (acc_shift >= 21'h110000)) begin
                    o_push = 1'b1;
                end else begin
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_UNIT;
                    o_cmd.unit = {6'b110110, cp_off[19:10]};
                    o_cmd.pair = 1'b1;
                    o_cmd.lo   = cp_off[9:0];
                end
                // a pushed result closes the sequence, whether from the final byte or a non-continuation byte
                if (o_push) begin
                    n_pend = 2'd0;
                    n_len  = 3'd0;
                    n_acc  = 21'd0;
                    if (o_cmd.kind == KIND_ERR) begin
                        n_cnt = 16'd0;
                    end else if (o_cmd.pair) begin
                        n_cnt = cnt_two;
                    end else begin
                        n_cnt = cnt_one;
                    end
                end
            end else if (i_in_byte == 8'h00) begin
                o_push      = 1'b1;
                o_cmd.kind  = KIND_END;
                o_cmd.count = r_cnt;
                n_cnt       = 16'd0;
            end else if (i_in_byte[7] == 1'b0) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_UNIT;
                o_cmd.unit = {8'd0, i_in_byte};
                n_cnt      = cnt_one;
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_len  = 3'd2;
                n_pend = 2'd1;
                n_acc  = {16'd0, i_in_byte[4:0]};
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_len  = 3'd3;
                n_pend = 2'd2;
                n_acc  = {17'd0, i_in_byte[3:0]};
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_len  = 3'd4;
                n_pend = 2'd3;
                n_acc  = {18'd0, i_in_byte[2:0]};
            end else begin
                o_push = 1'b1;
                n_cnt  = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_len  <= 3'd0;
            r_acc  <= 21'd0;
            r_cnt  <= 16'd0;
        end else begin
            r_pend <= n_pend;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// small command queue between the byte classifier and the result emitter
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue import u8u16_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// takes commands from the queue and drives the result register, splitting
// a surrogate pair over two transactions
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back import u8u16_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_kind        o_kind,
    output logic [15:0]  o_code_unit,
    output logic [15:0]  o_unit_count,
    output logic         o_last
);

    logic        r_valid, n_valid;
    logic        r_second, n_second;
    logic [9:0]  r_lo, n_lo;
    t_kind       r_kind, n_kind;
    logic [15:0] r_unit, n_unit;
    logic [15:0] r_count, n_count;
    logic        r_last, n_last;
    logic        out_free;

    assign out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_lo     = r_lo;
        n_kind   = r_kind;
        n_unit   = r_unit;
        n_count  = r_count;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (out_free) begin
            if (r_second) begin
                // low surrogate of a pair already started
                n_valid  = 1'b1;
                n_second = 1'b0;
                n_kind   = KIND_UNIT;
                n_unit   = {6'b110111, r_lo};
                n_count  = 16'd0;
                n_last   = 1'b1;
            end else if (!i_q_stat.empty) begin
                o_pop    = 1'b1;
                n_valid  = 1'b1;
                n_second = i_head.pair;
                n_lo     = i_head.lo;
                n_kind   = i_head.kind;
                n_unit   = i_head.unit;
                n_count  = i_head.count;
                n_last   = !i_head.pair;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_kind  <= n_kind;
        r_unit  <= n_unit;
        r_count <= n_count;
        r_last  <= n_last;
    end

    assign o_out_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_code_unit  = r_unit;
    assign o_unit_count = r_count;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### rtl/utf8_to_utf16_converter_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_unit
// utf-8 byte stream in, utf-16 code units, end and error results out
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the command queue is not full;
// the result register gives one transaction per cycle while i_out_stall is low
// a surrogate pair gives two output transactions, absorbed by the command queue
// the front stalls only when the command queue is full
// reset: synchronous, active low; clears sequence state, unit count, queue and
// output valid
`default_nettype none

`include "utf8_to_utf16_converter_unit_macros.svh"

module utf8_to_utf16_converter_unit import u8u16_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_code_unit,
    output logic [15:0]      o_unit_count,
    output logic             o_last
);

    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head;
    t_q_stat q_stat;
    t_kind   out_kind;

    u8u16_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (out_kind),
        .o_code_unit  (o_code_unit),
        .o_unit_count (o_unit_count),
        .o_last       (o_last)
    );

    assign o_in_stall = q_stat.full;
    assign o_kind     = out_kind;

    // no push into a full queue
    `U8U16_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
    // no pop from an empty queue
    `U8U16_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
    // end and error results are single, carry no code unit
    `U8U16_ASSERT_NOW(a_end_err_single, o_out_valid && (o_kind != KIND_UNIT),
        o_last && (o_code_unit == 16'd0))
    // the high half of a pair is always followed by a code unit transaction
    `U8U16_ASSERT_NEXT(a_pair_follows, o_out_valid && !o_last,
        o_out_valid && (o_kind == KIND_UNIT))

endmodule

`default_nettype wire
